FILE: design/ordered_list_engine_assert.svh
// assertion macros for the ordered list engine
// no dependencies; included inside module bodies
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define OLE_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define OLE_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/ole_pkg.sv
// shared types, codes and sizes for the ordered list engine
// no dependencies
package ole_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FUNC_W   = 3;
	localparam int POS_W    = 7;
	localparam int RUN_W    = 7;
	localparam int LEN_W    = 7;
	localparam int ST_W     = 2;
	localparam int SUM_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd4;
	localparam logic [FUNC_W-1:0] FN_INSERT_RUN = 3'd5;
	localparam logic [FUNC_W-1:0] FN_DELETE     = 3'd6;
	localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd7;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic signed [31:0] word_t;

	typedef struct packed {
		logic  ins;
		logic  rem;
		idx_t  pos;
		word_t value;
	} cell_ctl_t;

endpackage

FILE: design/ole_req_if.sv
// request channel of the ordered list engine
// depends on ole_pkg
interface ole_req_if;
	import ole_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [POS_W-1:0]         position;
	logic signed [31:0]       value;
	logic [RUN_W-1:0]         run_length;

	modport source (output valid, func, position, value, run_length, input ready);
	modport sink (input valid, func, position, value, run_length, output ready);
endinterface

FILE: design/ole_rsp_if.sv
// response channel of the ordered list engine
// depends on ole_pkg
interface ole_rsp_if;
	import ole_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ST_W-1:0]          status;
	logic [LEN_W-1:0]         length;
	logic signed [31:0]       removed_value;
	logic signed [31:0]       front_value;
	logic signed [31:0]       back_value;

	modport source (output valid, status, length, removed_value, front_value, back_value,
		input ready);
	modport sink (input valid, status, length, removed_value, front_value, back_value,
		output ready);
endinterface

FILE: design/ole_cell.sv
// one storage cell of the list row; shifts toward either neighbor or loads
// depends on ole_pkg
module ole_cell (
	input  logic              clk,
	input  ole_pkg::idx_t     idx,
	input  ole_pkg::cell_ctl_t ctl,
	input  ole_pkg::word_t    left,
	input  ole_pkg::word_t    right,
	output ole_pkg::word_t    val
);
	import ole_pkg::*;

	word_t val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx > ctl.pos) begin
				val_q <= left;
			end else if (idx == ctl.pos) begin
				val_q <= ctl.value;
			end
		end else if (ctl.rem && (idx >= ctl.pos)) begin
			val_q <= right;
		end
	end

	assign val = val_q;
endmodule

FILE: design/ordered_list_engine.sv
// top level of the ordered list engine: command decode, step control, result register
// depends on ole_pkg, ole_req_if, ole_rsp_if, ole_cell, ordered_list_engine_assert.svh
//
// channel | dir | payload
// req     | in  | func, position, value, run_length
// rsp     | out | status, length, removed_value, front_value, back_value
//
// a request is decoded on acceptance, then the cell row shifts in the run state:
// one shift for a push, pop, insert or delete, run_length shifts for an insert run,
// none for clear or a rejected request; the done state then loads the result register.
// the whole row shifts in a single step; the back value is muxed from the row.
// reset empties the list; cell contents are not cleared.
// a held result lets one more request in; intake then stops until the result leaves.
module ordered_list_engine (
	input logic      clk,
	input logic      arst_n,
	ole_req_if.sink  req,
	ole_rsp_if.source rsp
);
	import ole_pkg::*;
	`include "ordered_list_engine_assert.svh"

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] steps_q;
	logic             ins_q;
	idx_t             pos_q;
	word_t            value_q;
	logic [ST_W-1:0]  status_q;
	word_t            removed_q;
	logic             out_valid_q;
	logic [ST_W-1:0]  out_status_q;
	logic [LEN_W-1:0] out_length_q;
	word_t            out_removed_q;
	word_t            out_front_q;
	word_t            out_back_q;

	word_t            cell_val [CAPACITY];
	cell_ctl_t        ctl;

	logic [SUM_W-1:0] ext_pos, ext_cnt, ext_run, ext_cap;
	logic [ST_W-1:0]  nxt_status;
	logic [CNT_W-1:0] nxt_steps;
	logic             nxt_ins;
	logic [SUM_W-1:0] nxt_pos;
	logic             accept, load_out;
	idx_t             last_idx;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
	assign last_idx = idx_t'(count_q - CNT_W'(1));

	assign ext_pos = SUM_W'(req.position);
	assign ext_cnt = SUM_W'(count_q);
	assign ext_run = SUM_W'(req.run_length);
	assign ext_cap = SUM_W'(CAPACITY);

	always_comb begin
		nxt_status = ST_OK;
		nxt_steps  = '0;
		nxt_ins    = 1'b1;
		nxt_pos    = ext_pos;
		case (req.func)
			FN_PUSH_BACK, FN_PUSH_FRONT: begin
				nxt_pos = (req.func == FN_PUSH_BACK) ? ext_cnt : '0;
				if (ext_cnt >= ext_cap) nxt_status = ST_OVERFLOW;
				else nxt_steps = CNT_W'(1);
			end
			FN_POP_BACK, FN_POP_FRONT: begin
				nxt_ins = 1'b0;
				nxt_pos = (req.func == FN_POP_BACK) ? (ext_cnt - SUM_W'(1)) : '0;
				if (count_q == '0) nxt_status = ST_EMPTY;
				else nxt_steps = CNT_W'(1);
			end
			FN_INSERT: begin
				if (ext_pos > ext_cnt) nxt_status = ST_RANGE;
				else if (ext_cnt >= ext_cap) nxt_status = ST_OVERFLOW;
				else nxt_steps = CNT_W'(1);
			end
			FN_INSERT_RUN: begin
				if (ext_pos > ext_cnt) nxt_status = ST_RANGE;
				else if ((ext_cnt + ext_run) > ext_cap) nxt_status = ST_OVERFLOW;
				else nxt_steps = CNT_W'(req.run_length);
			end
			FN_DELETE: begin
				nxt_ins = 1'b0;
				if (count_q == '0) nxt_status = ST_EMPTY;
				else if (ext_pos >= ext_cnt) nxt_status = ST_RANGE;
				else nxt_steps = CNT_W'(1);
			end
			default: begin
				nxt_steps = '0;
			end
		endcase
	end

	// row control
	always_comb begin
		ctl.ins   = (state_q == S_RUN) && ins_q;
		ctl.rem   = (state_q == S_RUN) && !ins_q;
		ctl.pos   = pos_q;
		ctl.value = value_q;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_row
		ole_cell u_cell (
			.clk   (clk),
			.idx   (idx_t'(i)),
			.ctl   (ctl),
			.left  ((i == 0) ? word_t'(0) : cell_val[(i == 0) ? 0 : i - 1]),
			.right ((i == CAPACITY - 1) ? word_t'(0)
				: cell_val[(i == CAPACITY - 1) ? i : i + 1]),
			.val   (cell_val[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						steps_q <= nxt_steps;
						if (req.func == FN_CLEAR) count_q <= '0;
						state_q <= (nxt_steps == '0) ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					count_q <= ins_q ? (count_q + CNT_W'(1)) : (count_q - CNT_W'(1));
					steps_q <= steps_q - CNT_W'(1);
					if (steps_q == CNT_W'(1)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// request payload and result data
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q     <= nxt_ins;
			pos_q     <= idx_t'(nxt_pos);
			value_q   <= req.value;
			status_q  <= nxt_status;
			removed_q <= '0;
		end
		if ((state_q == S_RUN) && !ins_q) removed_q <= cell_val[pos_q];
		if (load_out) begin
			out_status_q  <= status_q;
			out_length_q  <= LEN_W'(count_q);
			out_removed_q <= removed_q;
			out_front_q   <= (count_q != '0) ? cell_val[0] : '0;
			out_back_q    <= (count_q != '0) ? cell_val[last_idx] : '0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.length        = out_length_q;
	assign rsp.removed_value = out_removed_q;
	assign rsp.front_value   = out_front_q;
	assign rsp.back_value    = out_back_q;

	`OLE_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY), "list count above capacity")
	`OLE_ASSERT_IMP(a_run_steps, clk, arst_n, state_q == S_RUN, steps_q != '0, "shift step with no steps left")
	`OLE_ASSERT_IMP(a_ins_room, clk, arst_n, (state_q == S_RUN) && ins_q, count_q < CNT_W'(CAPACITY), "insert shift on full list")
	`OLE_ASSERT_NXT(a_clear, clk, arst_n, accept && (req.func == FN_CLEAR), (count_q == '0) && (state_q == S_DONE), "clear did not empty list")
endmodule
